// ----- src/vaas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve anti-jam sequencer package
// Widths, register indexes, reset values, phase codes and the item structs
// shared by the sequencer, its remainder unit and its checker.
// ----------------------------------------------------------------------------
package vaas_pkg;

    localparam int TIME_W    = 32;   // width of the time stamp
    localparam int CUR_W     = 10;   // width of the averaged motor current
    localparam int CFG_T_W   = 16;   // width of the phase duration registers
    localparam int CFG_N_W   = 8;    // width of the done count register
    localparam int CHK_W     = 32;   // width of intervals and scheduled check times
    localparam int CYC_W     = CFG_T_W + 2;          // drive + 2 * pause + reverse
    localparam int CNT_W     = $clog2(TIME_W + 1);   // remainder step counter
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_DRIVE_TIME      = 3'd0;
    localparam cfg_idx_t CFG_PAUSE_TIME      = 3'd1;
    localparam cfg_idx_t CFG_REVERSE_TIME    = 3'd2;
    localparam cfg_idx_t CFG_DONE_COUNT      = 3'd3;
    localparam cfg_idx_t CFG_VALVE_INTERVAL  = 3'd4;
    localparam cfg_idx_t CFG_BATTERY_INTERVAL = 3'd5;

    localparam logic [CFG_T_W-1:0] RST_DRIVE_TIME     = 16'd60;
    localparam logic [CFG_T_W-1:0] RST_PAUSE_TIME     = 16'd30;
    localparam logic [CFG_T_W-1:0] RST_REVERSE_TIME   = 16'd2;
    localparam logic [CFG_N_W-1:0] RST_DONE_COUNT     = 8'd3;
    localparam logic [CHK_W-1:0]   RST_VALVE_INTERVAL = 32'd604800;
    localparam logic [CHK_W-1:0]   RST_BATT_INTERVAL  = 32'd86400;

    typedef enum logic [2:0] {
        PH_PAUSE   = 3'b001,
        PH_DRIVE   = 3'b010,
        PH_REVERSE = 3'b100
    } phase_t;

    typedef struct packed {
        logic              mode;
        logic              target_open;
        logic [TIME_W-1:0] now;
        logic [CUR_W-1:0]  motor_current;
    } in_item_t;

    typedef struct packed {
        logic             power_relay;
        logic             reverse_relay;
        logic             running;
        logic             position_open;
        logic             move_done;
        logic             sense_enable;
        logic [CHK_W-1:0] next_valve_check;
        logic [CHK_W-1:0] next_battery_check;
    } out_item_t;

endpackage

// ----- src/vaas_rem_serial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one dividend bit per cycle, that keeps only the
// remainder of the elapsed time over the cycle length.
// ----------------------------------------------------------------------------
module vaas_rem_serial (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [vaas_pkg::TIME_W-1:0] dividend,
    input  logic [vaas_pkg::CYC_W-1:0]  divisor,
    output logic                       done,
    output logic [vaas_pkg::CYC_W-1:0]  rem
);

    logic [vaas_pkg::TIME_W-1:0] dvd_reg;
    logic [vaas_pkg::CYC_W-1:0]  div_reg;
    logic [vaas_pkg::CYC_W-1:0]  rem_reg;
    logic [vaas_pkg::CYC_W-1:0]  rem_next;
    logic [vaas_pkg::CNT_W-1:0]  cnt_reg;
    logic                        done_reg;
    logic [vaas_pkg::CYC_W:0]    shifted;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        shifted = {rem_reg, dvd_reg[vaas_pkg::TIME_W-1]};
        if (shifted >= {1'b0, div_reg}) begin
            shifted = shifted - {1'b0, div_reg};
        end
        rem_next = shifted[vaas_pkg::CYC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= vaas_pkg::CNT_W'(vaas_pkg::TIME_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == vaas_pkg::CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[vaas_pkg::TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // A zero cycle length places the valve at the start of the cycle.
    assign rem  = (div_reg == '0) ? '0 : rem_reg;
    assign done = done_reg;

endmodule

// ----- src/valve_actuator_antijam_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve actuator anti-jam sequencer
// A tick while the valve runs waits on the bit-serial remainder unit (one
//   step per time bit) before its result is built; set items and idle
//   ticks skip it. A new item is taken only once the last result has
//   gone to the output register, which waits while that register is full.
// Reset: synchronous, active low; config registers return to their defaults.
// ----------------------------------------------------------------------------
module valve_actuator_antijam_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  vaas_pkg::cfg_idx_t             cfg_index,
    input  logic [vaas_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  vaas_pkg::in_item_t             s_data,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output vaas_pkg::out_item_t            m_data
);

    // Sequencer control. IDLE takes an item; DIV waits on the remainder unit
    // for a tick that arrives while the valve runs; HOLD hands the updated
    // state to the output register as soon as that register is free.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration registers.
    logic [vaas_pkg::CFG_T_W-1:0] drive_time_reg, drive_time_next;
    logic [vaas_pkg::CFG_T_W-1:0] pause_time_reg, pause_time_next;
    logic [vaas_pkg::CFG_T_W-1:0] reverse_time_reg, reverse_time_next;
    logic [vaas_pkg::CFG_N_W-1:0] done_count_reg, done_count_next;
    logic [vaas_pkg::CHK_W-1:0]   valve_int_reg, valve_int_next;
    logic [vaas_pkg::CHK_W-1:0]   batt_int_reg, batt_int_next;

    // Valve state.
    logic                          running_reg, running_next;
    logic                          goal_open_reg, goal_open_next;
    logic                          at_open_reg, at_open_next;
    logic [vaas_pkg::TIME_W-1:0]   move_start_reg, move_start_next;
    vaas_pkg::phase_t              phase_reg, phase_next;
    logic [vaas_pkg::CFG_N_W-1:0]  done_left_reg, done_left_next;
    logic                          power_reg, power_next;
    logic                          reverse_reg, reverse_next;
    logic                          sense_reg, sense_next;
    logic [vaas_pkg::CHK_W-1:0]    valve_at_reg, valve_at_next;
    logic [vaas_pkg::CHK_W-1:0]    batt_at_reg, batt_at_next;
    logic                          done_flag_reg, done_flag_next;

    // The tick being worked on.
    logic [vaas_pkg::TIME_W-1:0]   now_reg, now_next;
    logic                          cur_zero_reg, cur_zero_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    vaas_pkg::out_item_t           m_data_reg, m_data_next;

    // Remainder unit hookup and phase boundaries inside one cycle.
    logic                          div_start;
    logic                          div_done;
    logic [vaas_pkg::CYC_W-1:0]    pos_in_cycle;
    logic [vaas_pkg::CYC_W-1:0]    bnd_d;
    logic [vaas_pkg::CYC_W-1:0]    bnd_dp;
    logic [vaas_pkg::CYC_W-1:0]    bnd_dpr;
    logic [vaas_pkg::CYC_W-1:0]    cycle_len;
    logic [vaas_pkg::TIME_W-1:0]   elapsed;
    logic                          s_take;
    logic                          lt_d, lt_dp, lt_dpr;
    logic [vaas_pkg::CFG_N_W-1:0]  left_after;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;

    // The cycle is drive, pause, reverse, pause. The boundaries are derived
    // from registers the user must change only while idle; the block does not check.
    assign bnd_d     = vaas_pkg::CYC_W'(drive_time_reg);
    assign bnd_dp    = bnd_d + vaas_pkg::CYC_W'(pause_time_reg);
    assign bnd_dpr   = bnd_dp + vaas_pkg::CYC_W'(reverse_time_reg);
    assign cycle_len = bnd_dpr + vaas_pkg::CYC_W'(pause_time_reg);

    // Elapsed time since the move began wraps with the time stamp.
    assign elapsed   = s_data.now - move_start_reg;

    assign lt_d   = pos_in_cycle < bnd_d;
    assign lt_dp  = pos_in_cycle < bnd_dp;
    assign lt_dpr = pos_in_cycle < bnd_dpr;

    vaas_rem_serial u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (cycle_len),
        .done     (div_done),
        .rem      (pos_in_cycle)
    );

    always_comb begin
        state_next        = state_reg;
        drive_time_next   = drive_time_reg;
        pause_time_next   = pause_time_reg;
        reverse_time_next = reverse_time_reg;
        done_count_next   = done_count_reg;
        valve_int_next    = valve_int_reg;
        batt_int_next     = batt_int_reg;
        running_next      = running_reg;
        goal_open_next    = goal_open_reg;
        at_open_next      = at_open_reg;
        move_start_next   = move_start_reg;
        phase_next        = phase_reg;
        done_left_next    = done_left_reg;
        power_next        = power_reg;
        reverse_next      = reverse_reg;
        sense_next        = sense_reg;
        valve_at_next     = valve_at_reg;
        batt_at_next      = batt_at_reg;
        done_flag_next    = done_flag_reg;
        now_next          = now_reg;
        cur_zero_next     = cur_zero_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        div_start         = 1'b0;
        left_after        = done_left_reg;

        // Configuration writes; indexes beyond the list are dropped.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                vaas_pkg::CFG_DRIVE_TIME:
                    drive_time_next = cfg_wdata[vaas_pkg::CFG_T_W-1:0];
                vaas_pkg::CFG_PAUSE_TIME:
                    pause_time_next = cfg_wdata[vaas_pkg::CFG_T_W-1:0];
                vaas_pkg::CFG_REVERSE_TIME:
                    reverse_time_next = cfg_wdata[vaas_pkg::CFG_T_W-1:0];
                vaas_pkg::CFG_DONE_COUNT:
                    done_count_next = cfg_wdata[vaas_pkg::CFG_N_W-1:0];
                vaas_pkg::CFG_VALVE_INTERVAL:
                    valve_int_next = cfg_wdata[vaas_pkg::CHK_W-1:0];
                vaas_pkg::CFG_BATTERY_INTERVAL:
                    batt_int_next = cfg_wdata[vaas_pkg::CHK_W-1:0];
                default: begin
                end
            endcase
        end

        // The consumer frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    done_flag_next = 1'b0;
                    if (s_data.mode) begin
                        // A set item only starts a move when the valve is idle.
                        if (!running_reg) begin
                            goal_open_next  = s_data.target_open;
                            running_next    = 1'b1;
                            move_start_next = s_data.now;
                        end
                        state_next = ST_HOLD;
                    end else if (!running_reg) begin
                        // An idle tick retries a move that has not reached its goal.
                        if (goal_open_reg != at_open_reg) begin
                            running_next    = 1'b1;
                            move_start_next = s_data.now;
                        end
                        state_next = ST_HOLD;
                    end else begin
                        // A running tick needs the position inside the cycle first.
                        now_next      = s_data.now;
                        cur_zero_next = (s_data.motor_current == '0);
                        div_start     = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    sense_next = 1'b1;
                    // Switch the relays only when the phase changes.
                    priority if (lt_d && phase_reg != vaas_pkg::PH_DRIVE) begin
                        phase_next     = vaas_pkg::PH_DRIVE;
                        done_left_next = done_count_reg;
                        power_next     = 1'b1;
                        reverse_next   = goal_open_reg;
                    end else if (!lt_d && lt_dp && phase_reg != vaas_pkg::PH_PAUSE) begin
                        phase_next   = vaas_pkg::PH_PAUSE;
                        power_next   = 1'b0;
                        reverse_next = 1'b0;
                    end else if (!lt_dp && lt_dpr && phase_reg != vaas_pkg::PH_REVERSE) begin
                        phase_next   = vaas_pkg::PH_REVERSE;
                        power_next   = 1'b1;
                        reverse_next = !goal_open_reg;
                    end else if (!lt_dpr && phase_reg != vaas_pkg::PH_PAUSE) begin
                        phase_next   = vaas_pkg::PH_PAUSE;
                        power_next   = 1'b0;
                        reverse_next = 1'b0;
                    end else begin
                    end

                    // A stalled motor during drive counts toward the end of the move.
                    // The counter wraps from zero and is tested in every phase.
                    left_after = done_left_next;
                    if (cur_zero_reg && phase_next == vaas_pkg::PH_DRIVE) begin
                        left_after = done_left_next - 1'b1;
                    end
                    done_left_next = left_after;

                    if (left_after == '0) begin
                        at_open_next   = goal_open_reg;
                        running_next   = 1'b0;
                        power_next     = 1'b0;
                        reverse_next   = 1'b0;
                        sense_next     = 1'b0;
                        valve_at_next  = vaas_pkg::CHK_W'(now_reg) + valve_int_reg;
                        batt_at_next   = vaas_pkg::CHK_W'(now_reg) + batt_int_reg;
                        phase_next     = vaas_pkg::PH_PAUSE;
                        done_flag_next = 1'b1;
                    end
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD: begin
                // The result is a snapshot of the state after the update.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                   = 1'b1;
                    m_data_next.power_relay        = power_reg;
                    m_data_next.reverse_relay      = reverse_reg;
                    m_data_next.running            = running_reg;
                    m_data_next.position_open      = at_open_reg;
                    m_data_next.move_done          = done_flag_reg;
                    m_data_next.sense_enable       = sense_reg;
                    m_data_next.next_valve_check   = valve_at_reg;
                    m_data_next.next_battery_check = batt_at_reg;
                    state_next                     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            drive_time_reg   <= vaas_pkg::RST_DRIVE_TIME;
            pause_time_reg   <= vaas_pkg::RST_PAUSE_TIME;
            reverse_time_reg <= vaas_pkg::RST_REVERSE_TIME;
            done_count_reg   <= vaas_pkg::RST_DONE_COUNT;
            valve_int_reg    <= vaas_pkg::RST_VALVE_INTERVAL;
            batt_int_reg     <= vaas_pkg::RST_BATT_INTERVAL;
            running_reg      <= 1'b0;
            goal_open_reg    <= 1'b1;
            at_open_reg      <= 1'b1;
            move_start_reg   <= '0;
            phase_reg        <= vaas_pkg::PH_PAUSE;
            done_left_reg    <= vaas_pkg::RST_DONE_COUNT;
            power_reg        <= 1'b0;
            reverse_reg      <= 1'b0;
            sense_reg        <= 1'b0;
            valve_at_reg     <= '0;
            batt_at_reg      <= '0;
            done_flag_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            drive_time_reg   <= drive_time_next;
            pause_time_reg   <= pause_time_next;
            reverse_time_reg <= reverse_time_next;
            done_count_reg   <= done_count_next;
            valve_int_reg    <= valve_int_next;
            batt_int_reg     <= batt_int_next;
            running_reg      <= running_next;
            goal_open_reg    <= goal_open_next;
            at_open_reg      <= at_open_next;
            move_start_reg   <= move_start_next;
            phase_reg        <= phase_next;
            done_left_reg    <= done_left_next;
            power_reg        <= power_next;
            reverse_reg      <= reverse_next;
            sense_reg        <= sense_next;
            valve_at_reg     <= valve_at_next;
            batt_at_reg      <= batt_at_next;
            done_flag_reg    <= done_flag_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        cur_zero_reg <= cur_zero_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/vaas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve anti-jam sequencer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vaas_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input vaas_pkg::out_item_t            m_data
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A finished move leaves the valve stopped with the relays released.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.move_done |->
            !m_data.running && !m_data.power_relay && !m_data.sense_enable)
        else $error("move done with valve still active");

    // The reverse relay and current sensing are only active during a move,
    // and the reverse relay never closes without the power relay.
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (!m_data.running || !m_data.power_relay) |->
            !m_data.reverse_relay && (m_data.running || !m_data.sense_enable))
        else $error("relay or sensing active outside a move");

endmodule

bind valve_actuator_antijam_sequencer vaas_checker u_vaas_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the valve actuator anti-jam sequencer
// Sends valve items through the valid/ready input channel and checks every
// result item against its typed directed row or a cycle-free model of the
// sequencer kept in the bench. A short table of hand-written items comes
// first; random move sequences follow under register settings that include
// the extremes, with random back-pressure on both channels in all but one phase.
// ----------------------------------------------------------------------------
module tb_top;
    import vaas_pkg::*;

    // Item kinds carried in the mode field.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    // Percentage of cycles in which either side holds back.
    localparam int IDLE_PCT = 14;

    // Settle time after the last result, to let any work in the block finish.
    localparam int SETTLE_CYCLES = 40;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_idx_t              cfg_index = CFG_DRIVE_TIME;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    valve_actuator_antijam_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Backstop for a hung handshake. The slowest correct run is far shorter.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the sequencer: register settings and valve state.
    // ------------------------------------------------------------------------
    logic [CFG_T_W-1:0] vm_drive, vm_pause, vm_reverse;
    logic [CFG_N_W-1:0] vm_done_count;
    logic [CHK_W-1:0]   vm_valve_iv, vm_batt_iv;

    logic               vm_running, vm_goal_open, vm_at_open, vm_sensing;
    logic               vm_power, vm_rev;
    logic [TIME_W-1:0]  vm_move_start;
    phase_t             vm_phase;
    logic [CFG_N_W-1:0] vm_done_left;
    logic [CHK_W-1:0]   vm_valve_at, vm_batt_at;

    // Results that accepted items have caused but that have not come out yet.
    out_item_t pending_results[$];
    int        mismatches = 0;

    // When set, neither side holds back, so the block runs at full rate.
    bit quiet = 1'b0;

    // Time stamp of the move that the random stimulus is currently walking.
    logic [TIME_W-1:0] valve_clock = '0;

    // Advances the valve state by one item and returns the result it causes.
    // Everything in the result is taken after the update.
    function automatic out_item_t valve_predict(in_item_t it);
        out_item_t         res;
        logic [TIME_W-1:0] cyc, elapsed, pos, end_drive, end_pause, end_rev;
        logic              move_done;

        move_done = 1'b0;
        if (it.mode == MODE_SET) begin
            // A set item only takes effect on an idle valve.
            if (!vm_running) begin
                vm_goal_open  = it.target_open;
                vm_running    = 1'b1;
                vm_move_start = it.now;
            end
        end else if (!vm_running) begin
            // An idle tick only restarts a move; no phase is looked at here.
            if (vm_goal_open != vm_at_open) begin
                vm_running    = 1'b1;
                vm_move_start = it.now;
            end
        end else begin
            end_drive = TIME_W'(vm_drive);
            end_pause = end_drive + TIME_W'(vm_pause);
            end_rev   = end_pause + TIME_W'(vm_reverse);
            cyc       = end_rev + TIME_W'(vm_pause);
            elapsed   = it.now - vm_move_start;
            // A zero-length cycle pins the position in the cycle at zero.
            pos       = (cyc != '0) ? elapsed % cyc : '0;

            vm_sensing = 1'b1;
            if (pos < end_drive && vm_phase != PH_DRIVE) begin
                vm_phase     = PH_DRIVE;
                vm_done_left = vm_done_count;
                vm_power     = 1'b1;
                vm_rev       = vm_goal_open;
            end else if (pos >= end_drive && pos < end_pause && vm_phase != PH_PAUSE) begin
                vm_phase = PH_PAUSE;
                vm_power = 1'b0;
                vm_rev   = 1'b0;
            end else if (pos >= end_pause && pos < end_rev && vm_phase != PH_REVERSE) begin
                // The anti-jam kick runs against the target direction.
                vm_phase = PH_REVERSE;
                vm_power = 1'b1;
                vm_rev   = !vm_goal_open;
            end else if (pos >= end_rev && vm_phase != PH_PAUSE) begin
                vm_phase = PH_PAUSE;
                vm_power = 1'b0;
                vm_rev   = 1'b0;
            end

            // The counter wraps below zero and is tested in every phase.
            if (it.motor_current == '0 && vm_phase == PH_DRIVE)
                vm_done_left = vm_done_left - 1'b1;

            if (vm_done_left == '0) begin
                vm_at_open  = vm_goal_open;
                vm_running  = 1'b0;
                vm_power    = 1'b0;
                vm_rev      = 1'b0;
                vm_sensing  = 1'b0;
                vm_valve_at = it.now + vm_valve_iv;
                vm_batt_at  = it.now + vm_batt_iv;
                vm_phase    = PH_PAUSE;
                move_done   = 1'b1;
            end
        end

        res.power_relay        = vm_power;
        res.reverse_relay      = vm_rev;
        res.running            = vm_running;
        res.position_open      = vm_at_open;
        res.move_done          = move_done;
        res.sense_enable       = vm_sensing;
        res.next_valve_check   = vm_valve_at;
        res.next_battery_check = vm_batt_at;
        return res;
    endfunction

    // Picks the next random item. Most items walk a move from its set item
    // through ticks with growing time stamps; a few are pure noise.
    function automatic in_item_t next_valve_item();
        in_item_t          it;
        int                roll;
        logic [TIME_W-1:0] span;

        roll             = $urandom_range(0, 99);
        it.target_open   = 1'($urandom_range(0, 1));
        it.motor_current = CUR_W'($urandom_range(0, 1023));
        if (roll < 6) begin
            it.mode = 1'($urandom_range(0, 1));
            it.now  = $urandom;
        end else if (!vm_running) begin
            // A fresh move starts from a random time stamp, wrap included.
            it.mode     = (roll < 75) ? MODE_SET : MODE_TICK;
            it.now      = $urandom;
            valve_clock = it.now;
        end else begin
            // A set item here lands on a running valve and must be ignored.
            it.mode = (roll < 10) ? MODE_SET : MODE_TICK;
            span = (TIME_W'(vm_drive) + TIME_W'(vm_pause) * 2 + TIME_W'(vm_reverse)) / 3 + 2;
            if ($urandom_range(0, 99) < 20)
                span = 1;
            valve_clock = valve_clock + $urandom_range(0, span);
            it.now      = valve_clock;
            if ($urandom_range(0, 99) < 45)
                it.motor_current = '0;
            else
                it.motor_current = CUR_W'($urandom_range(1, 1023));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one item per call, with a random gap in front of it.
    // Valid stays high from one item to the next unless a gap is taken, so
    // it is never lowered and raised again in one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(in_item_t it, logic typed, out_item_t typed_res);
        out_item_t predicted;

        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = valve_predict(it);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Holds the input side until every result has come, then lets the block
    // finish any work in flight before the registers may change.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write per clock edge; the bench copy masks like the block.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DRIVE_TIME:       vm_drive      = val[CFG_T_W-1:0];
            CFG_PAUSE_TIME:       vm_pause      = val[CFG_T_W-1:0];
            CFG_REVERSE_TIME:     vm_reverse    = val[CFG_T_W-1:0];
            CFG_DONE_COUNT:       vm_done_count = val[CFG_N_W-1:0];
            CFG_VALVE_INTERVAL:   vm_valve_iv   = val[CHK_W-1:0];
            CFG_BATTERY_INTERVAL: vm_batt_iv    = val[CHK_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all six registers. Unused upper data bits carry random junk,
    // which the block has to drop.
    task automatic write_setting(logic [CFG_T_W-1:0] drive, logic [CFG_T_W-1:0] pause,
                                 logic [CFG_T_W-1:0] rev, logic [CFG_N_W-1:0] done_cnt,
                                 logic [CHK_W-1:0] valve_iv, logic [CHK_W-1:0] batt_iv);
        write_reg(CFG_DRIVE_TIME,       {16'($urandom), drive});
        write_reg(CFG_PAUSE_TIME,       {16'($urandom), pause});
        write_reg(CFG_REVERSE_TIME,     {16'($urandom), rev});
        write_reg(CFG_DONE_COUNT,       {24'($urandom), done_cnt});
        write_reg(CFG_VALVE_INTERVAL,   valve_iv);
        write_reg(CFG_BATTERY_INTERVAL, batt_iv);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed items. Result columns, left to right: power, reverse, running,
    // position, done, sense, next valve check, next battery check. Rows with
    // a zero in the typed column are checked against the bench model only.
    // The first move closes the valve under the reset settings, with a cycle
    // of 60 drive, 30 pause, 2 reverse and 30 pause ticks.
    // ------------------------------------------------------------------------
    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t res;
    } dir_row_t;

    localparam int DIR_ROWS = 16;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Idle tick with position equal to target: nothing moves.
        {MODE_TICK, 1'b0, 32'd0,          10'd0,    1'b1, 6'b000100, 32'd0, 32'd0},
        // Close the valve, then try to reopen it while it runs.
        {MODE_SET,  1'b0, 32'd100,        10'd0,    1'b1, 6'b001100, 32'd0, 32'd0},
        {MODE_SET,  1'b1, 32'd105,        10'd1023, 1'b1, 6'b001100, 32'd0, 32'd0},
        // Drive toward closed, pause, reverse kick, pause.
        {MODE_TICK, 1'b0, 32'd100,        10'd5,    1'b1, 6'b101101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd160,        10'd0,    1'b1, 6'b001101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd190,        10'd0,    1'b1, 6'b111101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd192,        10'd1023, 1'b1, 6'b001101, 32'd0, 32'd0},
        // Second cycle: the counter is reloaded and runs down on zero current.
        {MODE_TICK, 1'b0, 32'd222,        10'd0,    1'b1, 6'b101101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd223,        10'd0,    1'b1, 6'b101101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd224,        10'd1023, 1'b1, 6'b101101, 32'd0, 32'd0},
        {MODE_TICK, 1'b0, 32'd225,        10'd0,    1'b1, 6'b000010, 32'd605025, 32'd86625},
        {MODE_TICK, 1'b0, 32'hFFFF_FFFF,  10'd1023, 1'b1, 6'b000000, 32'd605025, 32'd86625},
        // Reopen across the wrap of the time stamp.
        {MODE_SET,  1'b1, 32'hFFFF_FFF0,  10'd0,    1'b1, 6'b001000, 32'd605025, 32'd86625},
        {MODE_TICK, 1'b0, 32'h0000_0010,  10'd0,    1'b0, 70'd0},
        {MODE_TICK, 1'b0, 32'h0000_0011,  10'd0,    1'b0, 70'd0},
        {MODE_TICK, 1'b0, 32'h0000_0012,  10'd0,    1'b0, 70'd0}
    };

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and a field-by-field comparison with
    // the oldest pending result.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing pending: %h", m_data);
                mismatches++;
            end else begin
                compare_field("power_relay", pending_results[0].power_relay,
                              m_data.power_relay);
                compare_field("reverse_relay", pending_results[0].reverse_relay,
                              m_data.reverse_relay);
                compare_field("running", pending_results[0].running, m_data.running);
                compare_field("position_open", pending_results[0].position_open,
                              m_data.position_open);
                compare_field("move_done", pending_results[0].move_done, m_data.move_done);
                compare_field("sense_enable", pending_results[0].sense_enable,
                              m_data.sense_enable);
                compare_field("next_valve_check", pending_results[0].next_valve_check,
                              m_data.next_valve_check);
                compare_field("next_battery_check", pending_results[0].next_battery_check,
                              m_data.next_battery_check);
                void'(pending_results.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main flow: reset, directed table, then random phases under settings
    // that include the register minimums, the maximums and zero values.
    // ------------------------------------------------------------------------
    initial begin
        int num_items;

        // The bench copy starts from the reset state of the block.
        vm_drive      = RST_DRIVE_TIME;
        vm_pause      = RST_PAUSE_TIME;
        vm_reverse    = RST_REVERSE_TIME;
        vm_done_count = RST_DONE_COUNT;
        vm_valve_iv   = RST_VALVE_INTERVAL;
        vm_batt_iv    = RST_BATT_INTERVAL;
        vm_running    = 1'b0;
        vm_goal_open  = 1'b1;
        vm_at_open    = 1'b1;
        vm_move_start = '0;
        vm_phase      = PH_PAUSE;
        vm_done_left  = RST_DONE_COUNT;
        vm_power      = 1'b0;
        vm_rev        = 1'b0;
        vm_sensing    = 1'b0;
        vm_valve_at   = '0;
        vm_batt_at    = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].res);

        // Phase 0 keeps the reset settings; every later phase loads new ones
        // only after the block has gone quiet.
        for (int k = 0; k <= 10; k++) begin
            if (k > 0) begin
                wait_all_results();
                case (k)
                    // Shortest legal cycle, checks scheduled at the tick itself.
                    1: write_setting(16'd1, 16'd1, 16'd1, 8'd1, 32'd0, 32'd0);
                    // Longest cycle and count; check times wrap around.
                    2: write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    // Zero-length cycle: the valve never drives.
                    3: write_setting(16'd0, 16'd0, 16'd0, 8'd0, $urandom, $urandom);
                    // Zero done count: zero current in drive wraps the counter.
                    4: write_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)),
                                     16'($urandom_range(1, 3)), 8'd0, $urandom, $urandom);
                    default: write_setting(16'($urandom_range(1, 24)),
                                           16'($urandom_range(1, 12)),
                                           16'($urandom_range(1, 6)),
                                           8'($urandom_range(1, 5)), $urandom, $urandom);
                endcase
            end

            // One phase runs with no back-pressure at all.
            quiet     = (k == 5);
            num_items = (k == 2) ? 40 : 160;
            for (int n = 0; n < num_items; n++) begin
                // Stop feeding in the middle of a phase until all results are in.
                if (k == 6 && n == num_items / 2)
                    wait_all_results();
                send_item(next_valve_item(), 1'b0, '0);
            end
        end

        wait_all_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/vaas_pkg.sv
src/vaas_rem_serial.sv
src/valve_actuator_antijam_sequencer.sv
src/vaas_checker.sv
bench/tb_top.sv
